### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked property that is not checked while the reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Clocked property that is checked at every edge, reset included.
`define ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif

`endif

### rtl/dwc_pkg.sv
// ----------------------------------------------------------------------------
// Depthwise convolution package
// Sizes, action codes and shared types of the depthwise 1D convolution block.
// ----------------------------------------------------------------------------
`default_nettype none

package dwc_pkg;

   localparam int MAX_CHANNELS = 256;
   localparam int TAPS         = 11;
   localparam int SAMPLE_BITS  = 16;

   localparam int HIST_DEPTH = TAPS - 1;
   localparam int HIST_BITS  = HIST_DEPTH * SAMPLE_BITS;
   localparam int FRAC_BITS  = SAMPLE_BITS - 4;
   localparam int PROD_BITS  = 2 * SAMPLE_BITS;
   localparam int ACC_BITS   = PROD_BITS + $clog2(TAPS);
   localparam int ADDR_BITS  = $clog2(MAX_CHANNELS);

   // Field widths of the stream items and the channel count register.
   localparam int CH_BITS  = 8;
   localparam int TAP_BITS = 4;
   localparam int ACT_BITS = 2;
   localparam int CFG_BITS = 9;
   localparam logic [CFG_BITS-1:0] CFG_RESET = 9'd192;

   // Result queue sizing.
   localparam int FIFO_DEPTH = 8;
   localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
   localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);
   localparam int OCC_BITS   = CNT_BITS + 1;

   typedef enum logic [ACT_BITS-1:0] {
      ACT_PUSH  = 2'd0,
      ACT_LOAD  = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef sample_type sample_vec_type [TAPS];

   typedef struct packed {
      logic                    sat;
      logic signed [SAMPLE_BITS-1:0] value;
      logic [CH_BITS-1:0]      channel;
   } result_type;

   typedef struct packed {
      logic prod_valid;
      logic part_valid;
      logic res_valid;
   } mac_occ_type;

endpackage

`default_nettype wire

### rtl/dwc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dwc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### rtl/dwc_mac.sv
// ----------------------------------------------------------------------------
// Depthwise convolution multiply-accumulate pipeline
// Tap products, grouped partial sums, then round and saturate to Q4.12.
// ----------------------------------------------------------------------------
`default_nettype none

module dwc_mac
   import dwc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire logic [CH_BITS-1:0] in_channel,
   input  wire sample_vec_type     in_samples,
   input  wire sample_vec_type     in_weights,
   output      logic               res_valid,
   output      result_type         res,
   output      mac_occ_type        occ
);

   localparam int GROUP_SIZE = 4;
   localparam int NUM_GROUPS = (TAPS + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int GROUP_BITS = PROD_BITS + $clog2(GROUP_SIZE);

   localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(2 ** (FRAC_BITS - 1));
   localparam logic signed [ACC_BITS-1:0] SAT_HI =
      {{(ACC_BITS - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] SAT_LO =
      {{(ACC_BITS - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

   logic signed [PROD_BITS-1:0]  prod_in [TAPS];
   logic signed [PROD_BITS-1:0]  prod_ff [TAPS];
   logic [CH_BITS-1:0]           prod_ch_ff;
   logic                         prod_valid_ff;

   logic signed [GROUP_BITS-1:0] part_in [NUM_GROUPS];
   logic signed [GROUP_BITS-1:0] part_ff [NUM_GROUPS];
   logic [CH_BITS-1:0]           part_ch_ff;
   logic                         part_valid_ff;

   result_type                   res_in;
   result_type                   res_ff;
   logic                         res_valid_ff;

   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         prod_in[i] = in_samples[i] * in_weights[i];
      end
   end

   // Each group adds at most four products.
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         part_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if (g * GROUP_SIZE + k < TAPS) begin
               part_in[g] = part_in[g] + GROUP_BITS'(prod_ff[g * GROUP_SIZE + k]);
            end
         end
      end
   end

   // Half an LSB is added before the arithmetic shift, so halves round up.
   always_comb begin
      logic signed [ACC_BITS-1:0] sum;
      logic signed [ACC_BITS-1:0] rnd;
      sum = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         sum = sum + ACC_BITS'(part_ff[g]);
      end
      rnd = (sum + ROUND_HALF) >>> FRAC_BITS;
      res_in.channel = part_ch_ff;
      if (rnd > SAT_HI) begin
         res_in.value = SAT_HI[SAMPLE_BITS-1:0];
         res_in.sat   = 1'b1;
      end else if (rnd < SAT_LO) begin
         res_in.value = SAT_LO[SAMPLE_BITS-1:0];
         res_in.sat   = 1'b1;
      end else begin
         res_in.value = rnd[SAMPLE_BITS-1:0];
         res_in.sat   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         part_valid_ff <= 1'b0;
         res_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= in_valid;
         part_valid_ff <= prod_valid_ff;
         res_valid_ff  <= part_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      prod_ch_ff <= in_channel;
      part_ff    <= part_in;
      part_ch_ff <= prod_ch_ff;
      res_ff     <= res_in;
   end

   assign res_valid      = res_valid_ff;
   assign res            = res_ff;
   assign occ.prod_valid = prod_valid_ff;
   assign occ.part_valid = part_valid_ff;
   assign occ.res_valid  = res_valid_ff;

endmodule

`default_nettype wire

### rtl/dwc_fifo.sv
// ----------------------------------------------------------------------------
// Depthwise convolution result queue
// Small register queue that holds finished results until they are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dwc_fifo
   import dwc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire result_type          push_data,
   input  wire logic                pop,
   output      logic                out_valid,
   output      result_type          out_data,
   output      logic [CNT_BITS-1:0] count
);

   result_type          entries_ff [FIFO_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;
   logic                do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = entries_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

`default_nettype wire

### rtl/depthwise_conv1d_11tap.sv
// ----------------------------------------------------------------------------
// Depthwise 1D convolution, 11 taps
// Per-channel centred FIR over an interleaved Q4.12 activation stream.
// ----------------------------------------------------------------------------
// Usage: the req stream carries one word per sample or command, in
// position-major order over the live channels. The action in req_tuser
// pushes a sample, loads one weight (channel, tap), or clears all history.
// Every push on a live channel gives one rsp word: the rounded and saturated
// sum of the 11 weights times the stored 10 samples and the new one, which is
// the filtered value for the position five samples back. Loads, clears,
// pushes on dead channels and the unused action give no word.
// The block takes one word per cycle, back to back, while req_tready is high,
// including repeated pushes on the same channel; the rate is set by one read
// and one write per cycle on the history and weight memories, with the
// written row forwarded to the next word. A result passes the input register,
// products, partial sums, round and saturate, and the result queue in order.
// When the receiver stalls, results wait in an eight-entry queue, and
// req_tready drops only when the queue and the words in flight would fill it.
// Reset sets the channel count to 192 and empties the pipeline; the history
// reads as zero through one valid flag per channel row, so no clearing pass
// is needed. Weights are undefined until they are loaded.
// The user writes the channel count on csr_wdata only while the stream is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module depthwise_conv1d_11tap
   import dwc_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   // Channel count register.
   input  wire logic                      csr_we,
   input  wire logic [CFG_BITS-1:0]       csr_wdata,
   // Request stream.
   input  wire logic                      req_tvalid,
   output      logic                      req_tready,
   // From bit 0: channel[7:0], tap[11:8], value[27:12], zero fill.
   input  wire logic [31:0]               req_tdata,
   // action[1:0].
   input  wire logic [ACT_BITS-1:0]       req_tuser,
   // Result stream.
   output      logic                      rsp_tvalid,
   input  wire logic                      rsp_tready,
   // From bit 0: out_channel[7:0], out_value[23:8].
   output      logic [23:0]               rsp_tdata,
   // saturated[0].
   output      logic [0:0]                rsp_tuser
);

   localparam int TAP_LSB   = CH_BITS;
   localparam int VALUE_LSB = CH_BITS + TAP_BITS;

   // Channel count register.
   logic [CFG_BITS-1:0]    cfg_ff;
   logic [CFG_BITS-1:0]    cfg_in;

   // Input register: the word taken in the previous cycle.
   logic                   req_accept;
   logic [CH_BITS-1:0]     req_channel;
   logic [ADDR_BITS-1:0]   req_addr;
   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   logic [ACT_BITS-1:0]    s1_action_ff;
   logic [CH_BITS-1:0]     s1_channel_ff;
   logic [TAP_BITS-1:0]    s1_tap_ff;
   sample_type             s1_value_ff;
   logic [ADDR_BITS-1:0]   s1_addr;
   logic                   s1_live;

   // Decoded effects of the word in the input register.
   logic                   hist_we;
   logic                   w_load;
   logic                   hist_clear;
   logic [TAPS-1:0]        w_we;

   // History rows, their valid flags and the forwarding path.
   logic [HIST_BITS-1:0]   hist_q;
   logic [HIST_BITS-1:0]   hist_cur;
   logic [HIST_BITS-1:0]   hist_new;
   logic [MAX_CHANNELS-1:0] hist_valid_ff;
   logic [MAX_CHANNELS-1:0] hist_valid_in;
   logic                   hfwd_ff;
   logic                   hfwd_in;
   logic [HIST_BITS-1:0]   hfwd_row_ff;

   // Weight memories, one per tap, and their forwarding path.
   logic [SAMPLE_BITS-1:0] wq [TAPS];
   logic                   wfwd_ff;
   logic                   wfwd_in;
   logic [TAP_BITS-1:0]    wfwd_tap_ff;
   sample_type             wfwd_value_ff;

   sample_vec_type         s1_samples;
   sample_vec_type         s1_weights;

   // Datapath and result queue.
   logic                   mac_valid;
   result_type             mac_res;
   mac_occ_type            mac_occ;
   logic                   fifo_valid;
   result_type             fifo_data;
   logic [CNT_BITS-1:0]    fifo_count;
   logic [OCC_BITS-1:0]    inflight;
   logic [OCC_BITS-1:0]    occupancy;

   // ------------------------------------------------------------------
   // Configuration
   // ------------------------------------------------------------------
   assign cfg_in = csr_we ? csr_wdata : cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ------------------------------------------------------------------
   // Input register. The memories are read with the channel of the word
   // on the request bus, so their data lines up with the input register.
   // ------------------------------------------------------------------
   assign req_accept  = req_tvalid && req_tready;
   assign req_channel = req_tdata[CH_BITS-1:0];
   assign req_addr    = ADDR_BITS'(req_channel);
   assign s1_valid_in = req_accept;
   assign s1_addr     = ADDR_BITS'(s1_channel_ff);

   // A channel is live below both the programmed count and the table size.
   assign s1_live = (CFG_BITS'(s1_channel_ff) < cfg_ff) &&
                    (32'(s1_channel_ff) < MAX_CHANNELS);

   always_comb begin
      hist_we    = 1'b0;
      w_load     = 1'b0;
      hist_clear = 1'b0;
      if (s1_valid_ff) begin
         unique case (s1_action_ff)
            ACT_PUSH:  hist_we    = s1_live;
            ACT_LOAD:  w_load     = s1_live;
            ACT_CLEAR: hist_clear = 1'b1;
            default:   ;
         endcase
      end
   end

   // A tap index beyond the last tap matches no memory and is dropped.
   always_comb begin
      for (int t = 0; t < TAPS; t++) begin
         w_we[t] = w_load && (s1_tap_ff == TAP_BITS'(t));
      end
   end

   // The next word reads its rows while this word writes them, so a hit
   // on the same channel takes the freshly written data instead.
   assign hfwd_in = hist_we && (s1_channel_ff == req_channel);
   assign wfwd_in = (w_we != '0) && (s1_channel_ff == req_channel);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_action_ff  <= req_tuser;
         s1_channel_ff <= req_channel;
         s1_tap_ff     <= req_tdata[TAP_LSB +: TAP_BITS];
         s1_value_ff   <= req_tdata[VALUE_LSB +: SAMPLE_BITS];
         hfwd_ff       <= hfwd_in;
         hfwd_row_ff   <= hist_new;
         wfwd_ff       <= wfwd_in;
         wfwd_tap_ff   <= s1_tap_ff;
         wfwd_value_ff <= s1_value_ff;
      end
   end

   // ------------------------------------------------------------------
   // History: row element 0 is the oldest sample. A row whose valid flag
   // is clear reads as all zero; a clear drops every flag at once.
   // ------------------------------------------------------------------
   dwc_ram #(
      .WIDTH(HIST_BITS),
      .DEPTH(MAX_CHANNELS)
   ) u_hist_ram (
      .clock(clock),
      .we   (hist_we),
      .waddr(s1_addr),
      .wdata(hist_new),
      .raddr(req_addr),
      .rdata(hist_q)
   );

   always_comb begin
      if (hfwd_ff) begin
         hist_cur = hfwd_row_ff;
      end else if (hist_valid_ff[s1_addr]) begin
         hist_cur = hist_q;
      end else begin
         hist_cur = '0;
      end
   end

   assign hist_new = {s1_value_ff, hist_cur[HIST_BITS-1:SAMPLE_BITS]};

   always_comb begin
      hist_valid_in = hist_valid_ff;
      if (hist_clear) begin
         hist_valid_in = '0;
      end else if (hist_we) begin
         hist_valid_in[s1_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_valid_ff <= '0;
      end else begin
         hist_valid_ff <= hist_valid_in;
      end
   end

   // ------------------------------------------------------------------
   // Weights: one memory per tap so a load writes a single word.
   // ------------------------------------------------------------------
   for (genvar t = 0; t < TAPS; t++) begin : g_wram
      dwc_ram #(
         .WIDTH(SAMPLE_BITS),
         .DEPTH(MAX_CHANNELS)
      ) u_wram (
         .clock(clock),
         .we   (w_we[t]),
         .waddr(s1_addr),
         .wdata(s1_value_ff),
         .raddr(req_addr),
         .rdata(wq[t])
      );
   end

   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         if (wfwd_ff && (wfwd_tap_ff == TAP_BITS'(i))) begin
            s1_weights[i] = wfwd_value_ff;
         end else begin
            s1_weights[i] = wq[i];
         end
      end
      for (int i = 0; i < HIST_DEPTH; i++) begin
         s1_samples[i] = hist_cur[i * SAMPLE_BITS +: SAMPLE_BITS];
      end
      s1_samples[TAPS-1] = s1_value_ff;
   end

   // ------------------------------------------------------------------
   // Multiply-accumulate and result queue.
   // ------------------------------------------------------------------
   dwc_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (hist_we),
      .in_channel(s1_channel_ff),
      .in_samples(s1_samples),
      .in_weights(s1_weights),
      .res_valid (mac_valid),
      .res       (mac_res),
      .occ       (mac_occ)
   );

   dwc_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (mac_valid),
      .push_data(mac_res),
      .pop      (rsp_tready),
      .out_valid(fifo_valid),
      .out_data (fifo_data),
      .count    (fifo_count)
   );

   // Every word in flight holds a queue slot until it leaves the pipeline,
   // so the queue can never overflow while the receiver stalls.
   assign inflight  = OCC_BITS'(s1_valid_ff) + OCC_BITS'(mac_occ.prod_valid) +
                      OCC_BITS'(mac_occ.part_valid) + OCC_BITS'(mac_occ.res_valid);
   assign occupancy = OCC_BITS'(fifo_count) + inflight;
   assign req_tready = (occupancy < OCC_BITS'(FIFO_DEPTH));

   assign rsp_tvalid   = fifo_valid;
   assign rsp_tdata    = {fifo_data.value, fifo_data.channel};
   assign rsp_tuser[0] = fifo_data.sat;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `ASSERT_CLK(a_queue_credit, clock, reset, (32'(fifo_count) + 32'(inflight)) <= FIFO_DEPTH, "result queue credit exceeded")
   `ASSERT_CLK(a_clear_rows, clock, reset, (s1_valid_ff && hist_clear) |=> (hist_valid_ff == '0), "clear left a history row valid")
   `ASSERT_CLK(a_push_marks_row, clock, reset, hist_we |=> hist_valid_ff[$past(s1_addr)], "push did not mark its history row")
   `ASSERT_NORST(a_reset_empty, clock, reset |=> (!rsp_tvalid && req_tready), "pipeline not empty after reset")

endmodule

`default_nettype wire

### tb/depthwise_conv1d_11tap_checker.sv
// ----------------------------------------------------------------------------
// Depthwise convolution result checker
// Watches the request, result and register ports of the block, keeps its own
// copy of weights, history and channel count, predicts every filtered word
// and compares the result stream with it in order.
// ----------------------------------------------------------------------------
module depthwise_conv1d_11tap_checker
   import dwc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CFG_BITS-1:0]  csr_wdata,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [31:0]          req_tdata,
   input  logic [ACT_BITS-1:0]  req_tuser,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [23:0]          rsp_tdata,
   input  logic [0:0]           rsp_tuser,
   output int                   error_total,
   output int                   pending_words,
   output int                   result_total,
   output int                   clipped_total
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MISMATCH_REPORTS = 10;

   sample_type          weight_store [MAX_CHANNELS][TAPS];
   sample_type          history_store [MAX_CHANNELS][HIST_DEPTH];
   logic [CFG_BITS-1:0] channel_count;
   result_type          filtered_q [$];
   int                  mismatches;
   int                  results;
   int                  clipped;

   // Dot product of the channel's weights with its history and the new sample,
   // rounded half up to Q4.12 and clipped. The new sample is then shifted in.
   function automatic result_type filter_sample(input logic [CH_BITS-1:0] ch,
                                                input sample_type smp);
      longint     acc;
      result_type res;
      acc = 0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
         acc += longint'(history_store[ch][i]) * longint'(weight_store[ch][i]);
      end
      acc += longint'(smp) * longint'(weight_store[ch][TAPS-1]);
      for (int i = 0; i < HIST_DEPTH - 1; i++) begin
         history_store[ch][i] = history_store[ch][i+1];
      end
      history_store[ch][HIST_DEPTH-1] = smp;
      acc = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
      res.sat = 1'b0;
      if (acc > 32767) begin
         acc = 32767;
         res.sat = 1'b1;
      end else if (acc < -32768) begin
         acc = -32768;
         res.sat = 1'b1;
      end
      res.channel = ch;
      res.value   = acc[SAMPLE_BITS-1:0];
      return res;
   endfunction

   always @(posedge clock) begin : monitor
      result_type         got;
      result_type         want;
      logic [CH_BITS-1:0] ch;
      logic [3:0]         tap;
      sample_type         val;
      if (reset) begin
         channel_count = CFG_RESET;
         foreach (history_store[c, i]) history_store[c][i] = '0;
         foreach (weight_store[c, t]) weight_store[c][t] = '0;
         filtered_q.delete();
         mismatches = 0;
         results    = 0;
         clipped    = 0;
      end else begin
         // Results are checked before this edge's request is predicted; the
         // pipeline latency keeps the two apart anyway.
         if (rsp_tvalid && rsp_tready) begin
            got.channel = rsp_tdata[7:0];
            got.value   = rsp_tdata[23:8];
            got.sat     = rsp_tuser[0];
            results++;
            if (got.sat) clipped++;
            if (filtered_q.size() == 0) begin
               if (mismatches < MISMATCH_REPORTS) begin
                  $display("[%0t] unexpected result: ch %0d value %0d sat %0b",
                           $realtime, got.channel, got.value, got.sat);
               end
               mismatches++;
            end else begin
               want = filtered_q.pop_front();
               if (got.channel !== want.channel || got.value !== want.value ||
                   got.sat !== want.sat) begin
                  if (mismatches < MISMATCH_REPORTS) begin
                     $display("[%0t] mismatch exp/got: ch %0d/%0d value %0d/%0d sat %0b/%0b",
                              $realtime, want.channel, got.channel, want.value,
                              got.value, want.sat, got.sat);
                  end
                  mismatches++;
               end
            end
         end
         if (csr_we) channel_count = csr_wdata;
         if (req_tvalid && req_tready) begin
            ch  = req_tdata[7:0];
            tap = req_tdata[11:8];
            val = req_tdata[27:12];
            case (req_tuser)
               ACT_CLEAR: begin
                  foreach (history_store[c, i]) history_store[c][i] = '0;
               end
               ACT_LOAD: begin
                  if (int'(ch) < int'(channel_count) && int'(tap) < TAPS) begin
                     weight_store[ch][tap] = val;
                  end
               end
               ACT_PUSH: begin
                  if (int'(ch) < int'(channel_count)) begin
                     filtered_q.push_back(filter_sample(ch, val));
                  end
               end
               default: ;
            endcase
         end
      end
      error_total   <= mismatches;
      pending_words <= filtered_q.size();
      result_total  <= results;
      clipped_total <= clipped;
   end

endmodule

### tb/depthwise_conv1d_11tap_tb.sv
// ----------------------------------------------------------------------------
// Depthwise 1D convolution testbench
// Drives weight loads, sample rows and history clears into the block under a
// series of channel counts, with random gaps on both streams and one long
// receiver stall; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module depthwise_conv1d_11tap_tb;
   import dwc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // The action code the block does not define; it must be ignored.
   localparam logic [ACT_BITS-1:0] ACT_UNUSED = 2'd3;

   localparam int CENTRE       = (TAPS - 1) / 2;
   localparam int TARGET_WORDS = 1850;
   // Quiet time after the last expected result before touching the register:
   // a word that gives no result may still be in the four-stage pipeline.
   localparam int DRAIN_CYCLES = 10;
   localparam int LONG_HOLD    = 300;
   localparam int LIMIT_CYCLES = 400000;
   // Idling stops once this many live words have gone in.
   localparam int QUIET_FROM   = 1550;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                csr_we     = 1'b0;
   logic [CFG_BITS-1:0] csr_wdata  = '0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [31:0]         req_tdata  = '0;
   logic [ACT_BITS-1:0] req_tuser  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [23:0]         rsp_tdata;
   logic [0:0]          rsp_tuser;

   int error_total;
   int pending_words;
   int result_total;
   int clipped_total;

   // Stimulus bookkeeping. The block leaves weights undefined until loaded,
   // so a push on a live channel is only made once all its taps are known.
   bit                  weight_loaded [MAX_CHANNELS][TAPS];
   logic [CFG_BITS-1:0] cur_count     = CFG_RESET;
   bit                  idle_on       = 1'b1;
   bit                  hold_request  = 1'b0;
   int                  words_sent    = 0;
   int                  live_words    = 0;
   int                  count_writes  = 0;
   int                  cycle_count   = 0;

   // Channel counts of the first frames: both extremes, zero, values past
   // the channel range and the reset value. Later frames draw at random.
   int count_plan [14] = '{4, 1, 256, 8, 3, 511, 0, 192, 2, 255, 16, 257, 1, 6};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   depthwise_conv1d_11tap u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   depthwise_conv1d_11tap_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .error_total   (error_total),
      .pending_words (pending_words),
      .result_total  (result_total),
      .clipped_total (clipped_total)
   );

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles, %0d results still expected",
                  cycle_count, pending_words);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Receiver. It mostly accepts, stalls in short random bursts while idling
   // is on, and once takes a long hold so that the result queue fills and the
   // block has to push back on its request side.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Random Q4.12 value. Style 0 spans the full range, style 1 stays within
   // +-1/8 and style 2 within +-2, so that results both clip and stay linear.
   function automatic logic [15:0] draw_q412(input int style);
      if ($urandom_range(0, 31) == 0) return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
      case (style)
         0:       return 16'($urandom);
         1:       return 16'($urandom_range(0, 1023)) - 16'd512;
         default: return 16'($urandom_range(0, 16383)) - 16'd8192;
      endcase
   endfunction

   // Offers one word and returns at the edge where it is taken. Valid stays
   // high into the next word unless a gap is drawn.
   task automatic send_word(input logic [ACT_BITS-1:0] act, input logic [7:0] ch,
                            input logic [3:0] tap, input logic [15:0] val);
      bit live;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, val, tap, ch};
      req_tuser  <= act;
      do @(posedge clock); while (!req_tready);
      words_sent++;
      live = int'(ch) < int'(cur_count);
      if (act == ACT_CLEAR || (live && (act == ACT_PUSH || act == ACT_LOAD))) live_words++;
      if (act == ACT_LOAD && live && int'(tap) < TAPS) weight_loaded[ch][tap] = 1'b1;
   endtask

   // Drops valid, then waits until every expected result has been taken and
   // the pipeline has had time to empty of words that give none.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_words != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(input logic [CFG_BITS-1:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_count = value;
      count_writes++;
   endtask

   // A word the block must ignore: the unused action, a push or load on a
   // dead channel, or a load with a tap past the last one. When every channel
   // is live, a "dead" load becomes an ordinary random load.
   task automatic send_noise(input int n_live);
      logic [7:0] dead_ch;
      dead_ch = (n_live < MAX_CHANNELS) ? 8'($urandom_range(n_live, MAX_CHANNELS - 1))
                                        : 8'($urandom);
      case ($urandom_range(0, 3))
         0: send_word(ACT_UNUSED, 8'($urandom), 4'($urandom), 16'($urandom));
         1: send_word((n_live < MAX_CHANNELS) ? ACT_PUSH : ACT_UNUSED, dead_ch,
                      4'($urandom), 16'($urandom));
         2: send_word(ACT_LOAD, (n_live > 0) ? 8'($urandom_range(0, n_live - 1)) : dead_ch,
                      4'($urandom_range(TAPS, 15)), 16'($urandom));
         default: send_word(ACT_LOAD, dead_ch, 4'($urandom), 16'($urandom));
      endcase
   endtask

   // One frame: set the channel count, make sure the chosen channels have all
   // their weights, maybe clear the history, then stream position-major rows
   // of samples followed by CENTRE rows of zeros as the trailing padding.
   task automatic run_frame(input logic [CFG_BITS-1:0] count, input bit hold_receiver);
      int used_ch [$];
      int n_live;
      int third;
      int positions;
      int w_style;
      int s_style;
      int have;
      if (count != cur_count) write_count(count);
      n_live = (int'(count) > MAX_CHANNELS) ? MAX_CHANNELS : int'(count);
      if (n_live == 0) begin
         // Every channel is dead; nothing may come back.
         repeat (8) send_noise(0);
         return;
      end
      if (n_live <= 12) begin
         for (int c = 0; c < n_live; c++) used_ch.push_back(c);
      end else begin
         // The edges of the live range plus one channel from each third.
         third = n_live / 3;
         used_ch.push_back(0);
         used_ch.push_back($urandom_range(1, third));
         used_ch.push_back($urandom_range(third + 1, 2 * third));
         used_ch.push_back($urandom_range(2 * third + 1, n_live - 2));
         used_ch.push_back(n_live - 1);
      end
      w_style = $urandom_range(0, 2);
      s_style = $urandom_range(0, 2);
      foreach (used_ch[k]) begin
         have = 0;
         for (int t = 0; t < TAPS; t++) if (weight_loaded[used_ch[k]][t]) have++;
         if (have < TAPS) begin
            for (int t = 0; t < TAPS; t++) begin
               send_word(ACT_LOAD, 8'(used_ch[k]), 4'(t), draw_q412(w_style));
            end
         end else if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               send_word(ACT_LOAD, 8'(used_ch[k]), 4'($urandom_range(0, TAPS - 1)),
                         draw_q412(w_style));
            end
         end
      end
      if ($urandom_range(0, 1) != 0) begin
         send_word(ACT_CLEAR, 8'($urandom), 4'($urandom), 16'($urandom));
      end
      if (hold_receiver) hold_request = 1'b1;
      positions = $urandom_range(2, 10);
      for (int p = 0; p < positions + CENTRE; p++) begin
         foreach (used_ch[k]) begin
            if ($urandom_range(0, 15) == 0) send_noise(n_live);
            // The tap field means nothing on a push, so it carries random bits.
            send_word(ACT_PUSH, 8'(used_ch[k]), 4'($urandom),
                      (p < positions) ? draw_q412(s_style) : 16'h0000);
         end
      end
   endtask

   initial begin : stimulus
      int               frame;
      logic [CFG_BITS-1:0] count;
      bit               hold_used;
      frame     = 0;
      hold_used = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset count of 192. Channel 0 gets weights of
      // -8.0 on the history taps and the smallest step on the newest tap.
      for (int t = 0; t < TAPS; t++) begin
         send_word(ACT_LOAD, 8'd0, 4'(t), (t == TAPS - 1) ? 16'h0001 : 16'h8000);
      end
      // Exactly half a step from an empty history rounds up to one step.
      send_word(ACT_PUSH, 8'd0, 4'd0, 16'h0800);
      send_word(ACT_CLEAR, 8'd0, 4'd0, 16'h0000);
      // Minus half a step rounds toward plus infinity, to zero.
      send_word(ACT_PUSH, 8'd0, 4'd0, 16'hF800);
      send_word(ACT_PUSH, 8'd0, 4'd0, 16'h8000);
      // Large history times -8.0 clips at the top of the range.
      send_word(ACT_PUSH, 8'd0, 4'd0, 16'h7FFF);
      send_word(ACT_LOAD, 8'd0, 4'd10, 16'h7FFF);
      // A full-scale newest tap against a negative sample clips at the bottom.
      send_word(ACT_PUSH, 8'd0, 4'd0, 16'h8000);
      // Loads with a tap past the last one are dropped.
      send_word(ACT_LOAD, 8'd0, 4'd15, 16'h1234);
      send_word(ACT_LOAD, 8'd0, 4'd11, 16'h4321);
      // Channels at and past the live count are ignored.
      send_word(ACT_LOAD, 8'd200, 4'd0, 16'h7FFF);
      send_word(ACT_PUSH, 8'd192, 4'd0, 16'h7FFF);
      send_word(ACT_PUSH, 8'd255, 4'd15, 16'hFFFF);
      send_word(ACT_UNUSED, 8'd0, 4'd0, 16'h1000);
      send_word(ACT_PUSH, 8'd0, 4'd0, 16'h0000);
      send_word(ACT_CLEAR, 8'hFF, 4'hF, 16'hFFFF);

      // Random frames under changing channel counts until enough live words
      // have gone through. The last stretch runs with no idling at all.
      while (live_words < TARGET_WORDS) begin
         if (frame < $size(count_plan)) begin
            count = CFG_BITS'(count_plan[frame]);
         end else begin
            case ($urandom_range(0, 9))
               0:       count = 9'd256;
               1:       count = CFG_BITS'($urandom_range(257, 511));
               2:       count = CFG_BITS'($urandom_range(13, 255));
               default: count = CFG_BITS'($urandom_range(1, 12));
            endcase
         end
         idle_on = (live_words < QUIET_FROM) ? ($urandom_range(0, 3) != 0) : 1'b0;
         run_frame(count, count == 9'd8 && !hold_used);
         if (count == 9'd8) hold_used = 1'b1;
         frame++;
      end

      wait_idle();
      $display("Sent %0d words (%0d live) in %0d frames across %0d channel-count writes.",
               words_sent, live_words, frame, count_writes);
      $display("Checked %0d filtered results, %0d clipped; %0d mismatches, %0d missing.",
               result_total, clipped_total, error_total, pending_words);
      if (error_total == 0 && pending_words == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
